/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while in reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also enforced during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/aari_pkg.sv */
// Shared request codes and corner constants for the box/ray core.
// No dependencies.
`default_nettype none
package aari_pkg;
	localparam logic [1:0] REQ_CLEAR     = 2'd0;
	localparam logic [1:0] REQ_ADD       = 2'd1;
	localparam logic [1:0] REQ_INTERSECT = 2'd2;
	localparam logic [1:0] REQ_INSIDE    = 2'd3;

	localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic [30:0]        TAU_SAT   = 31'h7FFF_FFFF;
	localparam logic [2:0]         LAST_FACE = 3'd5;
endpackage
`default_nettype wire

/* rtl/aari_req_if.sv */
// Request channel: valid/ready plus one request item.
// No dependencies.
`default_nettype none
interface aari_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;
	modport source (output valid, req_type, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, req_type, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
		output ready);
endinterface
`default_nettype wire

/* rtl/aari_res_if.sv */
// Result channel: valid/ready plus one result item.
// No dependencies.
`default_nettype none
interface aari_res_if;
	logic              valid;
	logic              ready;
	logic              hit;
	logic signed [31:0] hit_x;
	logic signed [31:0] hit_y;
	logic signed [31:0] hit_z;
	logic              inside_res;
	modport source (output valid, hit, hit_x, hit_y, hit_z, inside_res, input ready);
	modport sink (input valid, hit, hit_x, hit_y, hit_z, inside_res, output ready);
endinterface
`default_nettype wire

/* rtl/aabb_accumulate_ray_intersect_core.sv */
// Box accumulator with ray/face intersection and inside test.
// Depends on aari_pkg, aari_req_if, aari_res_if and assert_macros.svh.
//
// channel  dir  contents
// req      in   req_type, pos_x/y/z, dir_x/y/z
// res      out  hit, hit_x/y/z, inside_res
//
// Clear, add and inside items finish in the cycle they are taken.
// Intersect: per face a setup state, then either a skip or the divider, a multiply
// and check for each other axis and an update; then a step state per face.
// The divider yields one quotient bit per cycle and sets the worst-case run time.
// req.ready is low while an intersect runs and while a result waits untaken.
// Reset empties the box.
`default_nettype none
module aabb_accumulate_ray_intersect_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	aari_req_if.sink   req,
	aari_res_if.source res
);
	`include "assert_macros.svh"

	localparam int DW = 33 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam logic [63:0] RND = 64'((64'd1 << FRAC_BITS) - 64'd1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_FACE = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_CHK  = 7'b0010000,
		ST_UPD  = 7'b0100000,
		ST_NEXT = 7'b1000000
	} state_t;

	state_t state_q;
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];
	logic signed [31:0] p_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] cand_q [3];
	logic signed [31:0] best_q [3];
	logic signed [31:0] c_q;
	logic [2:0]    face_q;
	logic          oth_q;
	logic [DW-1:0] dvd_q, quo_q;
	logic [31:0]   rem_q, den_q;
	logic [CW-1:0] cnt_q;
	logic [30:0]   tau_q, best_tau_q;
	logic [62:0]   prod_q;
	logic          onface_q, found_q;
	logic          ovalid_q, ohit_q, oin_q;
	logic signed [31:0] ox_q, oy_q, oz_q;

	function automatic logic [1:0] oth_axis(input logic [1:0] d, input logic k);
		logic [1:0] r;
		unique case (d)
			2'd0:    r = k ? 2'd2 : 2'd1;
			2'd1:    r = k ? 2'd0 : 2'd2;
			2'd2:    r = k ? 2'd1 : 2'd0;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	logic        take, give;
	logic signed [31:0] rp [3];
	logic [1:0]  ax, ax2;
	logic signed [31:0] c_sel, den_s;
	logic signed [32:0] num;
	logic [32:0] num_mag;
	logic        skip;
	logic [32:0] rem_sh;
	logic        q_bit;
	logic [31:0] magv;
	logic [63:0] rsum, shv;
	logic signed [65:0] off, pt;
	logic        pt_in;
	logic        in_box;

	assign req.ready = (state_q == ST_IDLE) && (!ovalid_q || res.ready);
	assign take = req.valid && req.ready;
	assign give = ovalid_q && res.ready;
	assign res.valid = ovalid_q;
	assign res.hit = ohit_q;
	assign res.hit_x = ox_q;
	assign res.hit_y = oy_q;
	assign res.hit_z = oz_q;
	assign res.inside_res = oin_q;

	always_comb begin
		rp[0] = req.pos_x;
		rp[1] = req.pos_y;
		rp[2] = req.pos_z;
		in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (rp[i] < lo_q[i] || rp[i] > hi_q[i]) in_box = 1'b0;
		end
		ax = face_q[2:1];
		ax2 = oth_axis(ax, oth_q);
		c_sel = face_q[0] ? hi_q[ax] : lo_q[ax];
		den_s = v_q[ax];
		num = {c_sel[31], c_sel} - {p_q[ax][31], p_q[ax]};
		num_mag = num[32] ? 33'(-num) : 33'(num);
		skip = (den_s == 32'sd0) || ((num != 33'sd0) && (num[32] != den_s[31]));
		rem_sh = {rem_q, dvd_q[DW-1]};
		q_bit = rem_sh >= {1'b0, den_q};
		magv = v_q[ax2][31] ? 32'(-v_q[ax2]) : 32'(v_q[ax2]);
		rsum = {1'b0, prod_q} + (v_q[ax2][31] ? RND : 64'd0);
		shv = rsum >> FRAC_BITS;
		off = v_q[ax2][31] ? -$signed({2'b00, shv}) : $signed({2'b00, shv});
		pt = 66'(p_q[ax2]) + off;
		pt_in = (pt >= 66'(lo_q[ax2])) && (pt <= 66'(hi_q[ax2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= aari_pkg::COORD_MAX;
				hi_q[i] <= aari_pkg::COORD_MIN;
				p_q[i] <= '0;
				v_q[i] <= '0;
				cand_q[i] <= '0;
				best_q[i] <= '0;
			end
			c_q <= '0;
			face_q <= '0;
			oth_q <= 1'b0;
			dvd_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			cnt_q <= '0;
			tau_q <= '0;
			best_tau_q <= '0;
			prod_q <= '0;
			onface_q <= 1'b0;
			found_q <= 1'b0;
			ovalid_q <= 1'b0;
			ohit_q <= 1'b0;
			oin_q <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
		end else begin
			if (give && !(take && req.req_type != aari_pkg::REQ_INTERSECT))
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						ohit_q <= 1'b0;
						oin_q <= 1'b0;
						ox_q <= '0;
						oy_q <= '0;
						oz_q <= '0;
						unique case (req.req_type)
							aari_pkg::REQ_CLEAR: begin
								ovalid_q <= 1'b1;
								for (int i = 0; i < 3; i++) begin
									lo_q[i] <= aari_pkg::COORD_MAX;
									hi_q[i] <= aari_pkg::COORD_MIN;
								end
							end
							aari_pkg::REQ_ADD: begin
								ovalid_q <= 1'b1;
								for (int i = 0; i < 3; i++) begin
									if (rp[i] < lo_q[i]) lo_q[i] <= rp[i];
									if (rp[i] > hi_q[i]) hi_q[i] <= rp[i];
								end
							end
							aari_pkg::REQ_INSIDE: begin
								ovalid_q <= 1'b1;
								oin_q <= in_box;
							end
							default: begin
								p_q[0] <= req.pos_x;
								p_q[1] <= req.pos_y;
								p_q[2] <= req.pos_z;
								v_q[0] <= req.dir_x;
								v_q[1] <= req.dir_y;
								v_q[2] <= req.dir_z;
								for (int i = 0; i < 3; i++) best_q[i] <= '0;
								face_q <= '0;
								found_q <= 1'b0;
								state_q <= ST_FACE;
							end
						endcase
					end
				end
				ST_FACE: begin
					if (skip) begin
						state_q <= ST_NEXT;
					end else begin
						c_q <= c_sel;
						dvd_q <= {num_mag, {FRAC_BITS{1'b0}}};
						den_q <= den_s[31] ? 32'(-den_s) : 32'(den_s);
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == CW'(DW)) begin
						tau_q <= (quo_q[DW-1:31] != '0) ? aari_pkg::TAU_SAT : quo_q[30:0];
						oth_q <= 1'b0;
						onface_q <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						rem_q <= q_bit ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
						quo_q <= {quo_q[DW-2:0], q_bit};
						dvd_q <= {dvd_q[DW-2:0], 1'b0};
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					prod_q <= 63'(tau_q) * 63'(magv);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					cand_q[ax2] <= pt[31:0];
					onface_q <= onface_q && pt_in;
					oth_q <= 1'b1;
					state_q <= oth_q ? ST_UPD : ST_MUL;
				end
				ST_UPD: begin
					if (onface_q && (!found_q || tau_q < best_tau_q)) begin
						found_q <= 1'b1;
						best_tau_q <= tau_q;
						for (int i = 0; i < 3; i++) begin
							best_q[i] <= (2'(i) == ax) ? c_q : cand_q[i];
						end
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (face_q == aari_pkg::LAST_FACE) begin
						ovalid_q <= 1'b1;
						ohit_q <= found_q;
						ox_q <= best_q[0];
						oy_q <= best_q[1];
						oz_q <= best_q[2];
						state_q <= ST_IDLE;
					end else begin
						face_q <= face_q + 3'd1;
						state_q <= ST_FACE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_busy_not_ready, clk, arst_n, (state_q != ST_IDLE) |-> !req.ready,
		"request taken while busy")
	`ASSERT_CLK(a_ray_starts, clk, arst_n,
		(take && req.req_type == aari_pkg::REQ_INTERSECT) |=> (state_q == ST_FACE),
		"intersect did not start")
	`ASSERT_CLK(a_miss_zero, clk, arst_n,
		(ovalid_q && !ohit_q) |-> (ox_q == 32'sd0 && oy_q == 32'sd0 && oz_q == 32'sd0),
		"miss carries a point")
	`ASSERT_CLK(a_hit_excl, clk, arst_n, ovalid_q |-> !(ohit_q && oin_q),
		"hit and inside both set")
	`ASSERT_CLK(a_div_bound, clk, arst_n, (state_q == ST_DIV) |-> (cnt_q <= CW'(DW)),
		"divider count overrun")
endmodule
`default_nettype wire

/* tb/sv/aabb_accumulate_ray_intersect_core_test.sv */
// Self-checking bench for the box accumulator with ray/face intersection.
// Depends on aari_pkg, aari_req_if, aari_res_if and the core; runs directed rows then random items.
`default_nettype none
module aabb_accumulate_ray_intersect_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int N_RANDOM = 1900;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [31:0] px, py, pz, dx, dy, dz;
	} req_t;

	typedef struct packed {
		logic hit;
		logic signed [31:0] hx, hy, hz;
		logic in_box;
	} res_t;

	typedef struct {
		req_t r;
		bit typed;
		res_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	aari_req_if req();
	aari_res_if res();

	aabb_accumulate_ray_intersect_core #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic signed [31:0] box_lo[3];
	logic signed [31:0] box_hi[3];
	res_t expected_q[$];
	int n_errors = 0;
	int n_results = 0;
	int n_hits = 0;
	int n_inside = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		n_errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	function automatic logic signed [63:0] offset_along(input logic [63:0] tau,
			input logic signed [63:0] dv);
		logic [63:0] m;
		logic [63:0] mask;
		m = tau * (dv < 0 ? -dv : dv);
		mask = (64'd1 << FRAC) - 1;
		if (dv >= 0)
			return m >> FRAC;
		return -((m + mask) >> FRAC);
	endfunction

	function automatic res_t box_step(input req_t r);
		res_t o;
		logic signed [63:0] p[3], v[3], pt[3], best[3];
		logic signed [63:0] c, num;
		logic [63:0] tau, best_tau;
		bit on_face;
		o = '0;
		p[0] = r.px; p[1] = r.py; p[2] = r.pz;
		v[0] = r.dx; v[1] = r.dy; v[2] = r.dz;
		best_tau = 0;
		for (int i = 0; i < 3; i++) best[i] = 0;
		case (r.kind)
			aari_pkg::REQ_CLEAR: begin
				for (int i = 0; i < 3; i++) begin
					box_lo[i] = aari_pkg::COORD_MAX;
					box_hi[i] = aari_pkg::COORD_MIN;
				end
			end
			aari_pkg::REQ_ADD: begin
				for (int i = 0; i < 3; i++) begin
					if (p[i] < box_lo[i]) box_lo[i] = p[i];
					if (p[i] > box_hi[i]) box_hi[i] = p[i];
				end
			end
			aari_pkg::REQ_INSIDE: begin
				o.in_box = 1'b1;
				for (int i = 0; i < 3; i++)
					if (p[i] < box_lo[i] || p[i] > box_hi[i]) o.in_box = 1'b0;
			end
			default: begin
				for (int d = 0; d < 3; d++) begin
					for (int f = 0; f < 2; f++) begin
						c = f ? box_hi[d] : box_lo[d];
						num = c - p[d];
						if (v[d] == 0) continue;
						if (num != 0 && ((num < 0) != (v[d] < 0))) continue;
						tau = ((num < 0 ? -num : num) << FRAC) / (v[d] < 0 ? -v[d] : v[d]);
						if (tau > 64'h7FFF_FFFF) tau = 64'h7FFF_FFFF;
						on_face = 1'b1;
						for (int i = 0; i < 3; i++) begin
							if (i == d) begin
								pt[i] = c;
							end else begin
								pt[i] = p[i] + offset_along(tau, v[i]);
								if (pt[i] < box_lo[i] || pt[i] > box_hi[i]) on_face = 1'b0;
							end
						end
						if (on_face && (!o.hit || tau < best_tau)) begin
							o.hit = 1'b1;
							best_tau = tau;
							for (int i = 0; i < 3; i++) best[i] = pt[i];
						end
					end
				end
				o.hx = best[0][31:0];
				o.hy = best[1][31:0];
				o.hz = best[2][31:0];
			end
		endcase
		return o;
	endfunction

	// Random coordinates: mostly small and near the box, sometimes full range.
	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? aari_pkg::COORD_MAX : aari_pkg::COORD_MIN;
			2: return 32'sd0;
			default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_dir();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'sd0;
			2: return $urandom_range(0, 1) ? aari_pkg::COORD_MAX : aari_pkg::COORD_MIN;
			default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send(input req_t r);
		while (!calm && $urandom_range(0, 99) < 9) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		{req.req_type, req.pos_x, req.pos_y, req.pos_z, req.dir_x, req.dir_y, req.dir_z} <= r;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// Accept, predict and check on the rising edge.
	always @(posedge clk) begin
		if (req.valid && req.ready) begin
			expected_q.push_back(box_step({req.req_type, req.pos_x, req.pos_y, req.pos_z,
				req.dir_x, req.dir_y, req.dir_z}));
		end
		if (res.valid && res.ready) begin
			res_t w;
			n_results++;
			if (expected_q.size() == 0) begin
				report("unexpected item", {63'd0, res.hit}, 64'd0);
			end else begin
				w = expected_q.pop_front();
				if (res.hit !== w.hit) report("hit", 64'(res.hit), 64'(w.hit));
				if (res.hit_x !== w.hx) report("hit_x", 64'(res.hit_x), 64'(w.hx));
				if (res.hit_y !== w.hy) report("hit_y", 64'(res.hit_y), 64'(w.hy));
				if (res.hit_z !== w.hz) report("hit_z", 64'(res.hit_z), 64'(w.hz));
				if (res.inside_res !== w.in_box)
					report("inside_res", 64'(res.inside_res), 64'(w.in_box));
				n_hits += w.hit;
				n_inside += w.in_box;
			end
		end
	end

	// Typed-in expectations for the directed rows.
	res_t typed_q[$];
	always @(posedge clk) begin
		if (res.valid && res.ready && typed_q.size() != 0) begin
			res_t t;
			t = typed_q.pop_front();
			if (t !== 'x && {res.hit, res.hit_x, res.hit_y, res.hit_z, res.inside_res} !== t
					&& t[0] !== 1'bz)
				report("directed row", 64'({res.hit, res.inside_res}),
					64'({t.hit, t.in_box}));
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			res.ready <= 1'b0;
		else
			res.ready <= calm || $urandom_range(0, 99) >= 9;
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("watchdog: no progress");
			$display("aabb_accumulate_ray_intersect_core_test: done, errors");
			$finish;
		end
	end

	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	row_t rows[$];

	function automatic req_t mk(input logic [1:0] k, input logic signed [31:0] px, py, pz,
			input logic signed [31:0] dx, dy, dz);
		return {k, px, py, pz, dx, dy, dz};
	endfunction

	initial begin
		res_t none;
		res_t yes;
		res_t skip;
		req_t r;
		int k;
		none = '0;
		yes = '0;
		yes.in_box = 1'b1;
		skip = 'z;
		req.valid = 1'b0;
		{req.req_type, req.pos_x, req.pos_y, req.pos_z, req.dir_x, req.dir_y, req.dir_z} = '0;
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = aari_pkg::COORD_MAX;
			box_hi[i] = aari_pkg::COORD_MIN;
		end
		rows = '{
			'{mk(aari_pkg::REQ_INSIDE, 0, 0, 0, 0, 0, 0), 1, none},
			'{mk(aari_pkg::REQ_INTERSECT, 0, 0, 0, ONE, ONE, ONE), 1, none},
			'{mk(aari_pkg::REQ_ADD, -ONE, -ONE, -ONE, 0, 0, 0), 1, none},
			'{mk(aari_pkg::REQ_ADD, ONE, ONE, ONE, -1, -1, -1), 1, none},
			'{mk(aari_pkg::REQ_INSIDE, 0, 0, 0, 0, 0, 0), 1, yes},
			'{mk(aari_pkg::REQ_INSIDE, ONE, -ONE, ONE, 0, 0, 0), 1, yes},
			'{mk(aari_pkg::REQ_INSIDE, ONE + 1, 0, 0, 0, 0, 0), 1, none},
			'{mk(aari_pkg::REQ_INTERSECT, -3 * ONE, 0, 0, ONE, 0, 0), 0, skip},
			'{mk(aari_pkg::REQ_INTERSECT, 3 * ONE, 0, 0, -ONE, 0, 0), 0, skip},
			'{mk(aari_pkg::REQ_INTERSECT, 0, 0, 0, 0, 0, ONE), 0, skip},
			'{mk(aari_pkg::REQ_INTERSECT, 0, 0, 0, 0, 0, 0), 1, none},
			'{mk(aari_pkg::REQ_INTERSECT, 0, -3 * ONE, 0, 0, -ONE, 0), 1, none},
			'{mk(aari_pkg::REQ_INTERSECT, -ONE, 0, 0, 1, 0, 0), 0, skip},
			'{mk(aari_pkg::REQ_INTERSECT, aari_pkg::COORD_MIN, 0, 0, 1, 1, 0), 0, skip},
			'{mk(aari_pkg::REQ_INTERSECT, aari_pkg::COORD_MIN, aari_pkg::COORD_MAX,
				aari_pkg::COORD_MIN, aari_pkg::COORD_MAX, aari_pkg::COORD_MIN,
				aari_pkg::COORD_MAX), 0, skip},
			'{mk(aari_pkg::REQ_ADD, aari_pkg::COORD_MAX, aari_pkg::COORD_MIN,
				aari_pkg::COORD_MAX, 0, 0, 0), 0, skip},
			'{mk(aari_pkg::REQ_INTERSECT, 0, 0, 0, aari_pkg::COORD_MIN, 1, -1), 0, skip},
			'{mk(aari_pkg::REQ_INSIDE, aari_pkg::COORD_MAX, aari_pkg::COORD_MIN,
				aari_pkg::COORD_MAX, 0, 0, 0), 1, yes},
			'{mk(aari_pkg::REQ_CLEAR, -1, -1, -1, -1, -1, -1), 1, none},
			'{mk(aari_pkg::REQ_INSIDE, 0, 0, 0, 0, 0, 0), 1, none},
			'{mk(aari_pkg::REQ_ADD, 0, 0, 0, 0, 0, 0), 1, none},
			'{mk(aari_pkg::REQ_INTERSECT, 0, 0, 0, ONE, ONE, ONE), 0, skip}
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			typed_q.push_back(rows[i].typed ? rows[i].want : skip);
			send(rows[i].r);
		end
		k = 0;
		while (k < N_RANDOM) begin
			calm = (k >= 700 && k < 900);
			// Mostly: clear, build a box from a few points, then query it.
			if ($urandom_range(0, 9) < 8) begin
				send(mk(aari_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom));
				k++;
				repeat ($urandom_range(1, 4)) begin
					send(mk(aari_pkg::REQ_ADD, rand_coord(), rand_coord(), rand_coord(),
						$urandom, $urandom, $urandom));
					k++;
				end
				repeat ($urandom_range(2, 8)) begin
					r = mk($urandom_range(0, 2) ? aari_pkg::REQ_INTERSECT : aari_pkg::REQ_INSIDE,
						rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
						rand_dir());
					send(r);
					k++;
				end
			end else begin
				send({2'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
					32'($urandom), 32'($urandom), 32'($urandom)});
				k++;
			end
		end
		req.valid <= 1'b0;
		calm = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d results checked, %0d hits, %0d inside answers", n_results, n_hits,
			n_inside);
		if (n_errors == 0)
			$display("aabb_accumulate_ray_intersect_core_test: done, clean");
		else
			$display("aabb_accumulate_ray_intersect_core_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
